@@ src/wsrd_pkg.sv @@
`timescale 1ns / 1ps
package wsrd_pkg;
   localparam int MaxBytes = 8192;
   localparam int CntW = $clog2(MaxBytes + 2);

   localparam logic [3:0] OpCont = 4'd0;
   localparam logic [3:0] OpText = 4'd1;
   localparam logic [3:0] OpBinary = 4'd2;
   localparam logic [3:0] OpClose = 4'd8;
   localparam logic [3:0] OpPing = 4'd9;
   localparam logic [3:0] OpPong = 4'd10;

   typedef enum logic [1:0] {
      KIND_TEXT = 2'd0,
      KIND_PONG = 2'd1,
      KIND_ACCEPT = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic byte_valid;
      logic last;
   } rsp_type;

   localparam int RspW = $bits(rsp_type);
endpackage

@@ src/wsrd_front.sv @@
`timescale 1ns / 1ps
module wsrd_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_action,
   input  logic [7:0] in_byte,
   output logic q_valid,
   input  logic q_ready,
   output wsrd_pkg::rsp_type q_data
);
   typedef enum logic [3:0] {
      PH_SHAKE = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DEAD = 4'b1000
   } phase_type;

   localparam int W = wsrd_pkg::CntW;
   localparam logic [W-1:0] Lim = W'(wsrd_pkg::MaxBytes);
   localparam logic [W:0] LimX = (W+1)'(wsrd_pkg::MaxBytes);

   phase_type phase_ff, phase_in;
   logic [3:0] pidx_ff, pidx_in;
   logic pbad_ff, pbad_in;
   logic [1:0] blank_ff, blank_in;
   logic [W-1:0] reply_ff, reply_in;
   logic [3:0] hidx_ff, hidx_in;
   logic fin_ff, fin_in;
   logic [3:0] fkind_ff, fkind_in;
   logic masked_ff, masked_in;
   logic [W-1:0] flen_ff, flen_in;
   logic ovf_ff, ovf_in;
   logic [W-1:0] pay_ff, pay_in;
   logic [31:0] key_ff, key_in;
   logic [1:0] frag_ff, frag_in;
   logic [W-1:0] msg_ff, msg_in;
   logic [3:0] ext_ff, ext_in;

   logic fire, emit;
   wsrd_pkg::rsp_type r;

   assign in_ready = q_ready;
   assign fire = in_valid && in_ready;
   assign q_valid = fire && emit;
   assign q_data = r;

   function automatic logic [7:0] status_char(input logic [3:0] i);
      case (i)
         4'd0: status_char = 8'h48;
         4'd1: status_char = 8'h54;
         4'd2: status_char = 8'h54;
         4'd3: status_char = 8'h50;
         4'd4: status_char = 8'h2f;
         4'd5: status_char = 8'h31;
         4'd6: status_char = 8'h2e;
         4'd7: status_char = 8'h31;
         4'd8: status_char = 8'h20;
         4'd9: status_char = 8'h31;
         4'd10: status_char = 8'h30;
         4'd11: status_char = 8'h31;
         default: status_char = 8'h00;
      endcase
   endfunction

   logic [7:0] blank_char;
   logic [W+8:0] shl;
   logic [3:0] hlen;
   logic [W:0] sum_h, sum_m;
   logic text_cls;
   logic [7:0] kb;
   logic is_last;
   logic tfin;
   logic [3:0] tk;
   logic [1:0] tfrag;

   always_comb begin
      phase_in = phase_ff; pidx_in = pidx_ff; pbad_in = pbad_ff; blank_in = blank_ff;
      reply_in = reply_ff; hidx_in = hidx_ff; fin_in = fin_ff; fkind_in = fkind_ff;
      masked_in = masked_ff; flen_in = flen_ff; ovf_in = ovf_ff; pay_in = pay_ff;
      key_in = key_ff; frag_in = frag_ff; msg_in = msg_ff; ext_in = ext_ff;
      emit = 1'b0;
      r = '0;
      blank_char = blank_ff[0] ? 8'd10 : 8'd13;
      shl = '0; hlen = '0; sum_h = '0; sum_m = '0; kb = '0; is_last = 1'b0;
      tfin = fin_ff; tk = fkind_ff; tfrag = frag_ff;
      text_cls = (fkind_ff == 4'd1) || (fkind_ff == 4'd0 && frag_ff == 2'd1);
      if (in_action) begin
         phase_in = PH_SHAKE; pidx_in = '0; pbad_in = 1'b0; blank_in = '0;
         reply_in = '0; hidx_in = '0; fin_in = 1'b0; fkind_in = '0; masked_in = 1'b0;
         flen_in = '0; ovf_in = 1'b0; pay_in = '0; key_in = '0; frag_in = '0;
         msg_in = '0; ext_in = '0;
      end else begin
         case (phase_ff)
            PH_SHAKE: begin
               reply_in = reply_ff + 1'b1;
               if (reply_ff >= Lim) begin
                  phase_in = PH_DEAD; emit = 1'b1; r.kind = wsrd_pkg::KIND_ERROR;
               end else begin
                  if (pidx_ff < 4'd12 && !pbad_ff) begin
                     if (in_byte == status_char(pidx_ff) ||
                         (pidx_ff == 4'd7 && in_byte == 8'h30))
                        pidx_in = pidx_ff + 1'b1;
                     else
                        pbad_in = 1'b1;
                  end
                  if (in_byte == blank_char) begin
                     if (blank_ff == 2'd3) begin
                        emit = 1'b1;
                        if (pbad_in || pidx_in < 4'd12) begin
                           phase_in = PH_DEAD; r.kind = wsrd_pkg::KIND_ERROR;
                        end else begin
                           phase_in = PH_HEADER; hidx_in = '0;
                           r.kind = wsrd_pkg::KIND_ACCEPT;
                        end
                     end else begin
                        blank_in = blank_ff + 1'b1;
                     end
                  end else begin
                     blank_in = (in_byte == 8'd13) ? 2'd1 : 2'd0;
                  end
               end
            end
            PH_HEADER: begin
               if (hidx_ff == 4'd0) begin
                  fin_in = in_byte[7]; fkind_in = in_byte[3:0]; hidx_in = 4'd1;
               end else begin
                  if (hidx_ff == 4'd1) begin
                     masked_in = in_byte[7];
                     ext_in = (in_byte[6:0] == 7'd126) ? 4'd2 :
                              (in_byte[6:0] == 7'd127) ? 4'd8 : 4'd0;
                     flen_in = (ext_in != 4'd0) ? '0 : W'(in_byte[6:0]);
                     ovf_in = 1'b0; key_in = '0;
                  end else if (hidx_ff - 4'd2 < ext_ff) begin
                     shl = {1'b0, flen_ff, in_byte};
                     if (shl > (W+9)'(wsrd_pkg::MaxBytes)) begin
                        ovf_in = 1'b1; flen_in = Lim + 1'b1;
                     end else begin
                        flen_in = shl[W-1:0];
                     end
                  end else begin
                     key_in = {key_ff[23:0], in_byte};
                  end
                  hidx_in = hidx_ff + 1'b1;
                  hlen = 4'd2 + ext_in + (masked_in ? 4'd4 : 4'd0);
                  if (hidx_in >= hlen) begin
                     sum_h = (W+1)'(hlen) + {1'b0, flen_in};
                     sum_m = {1'b0, msg_ff} + {1'b0, flen_in};
                     tk = fkind_in; tfin = fin_in;
                     if (ovf_in || flen_in > Lim || sum_h > LimX ||
                         (tk[3] && (!tfin || flen_in > W'(125))) ||
                         (tk == 4'd0 && (frag_ff == 2'd0 || sum_m > LimX)) ||
                         ((tk == 4'd1 || tk == 4'd2) && frag_ff != 2'd0) ||
                         (tk != 4'd0 && tk != 4'd1 && tk != 4'd2 &&
                          tk != 4'd9 && tk != 4'd10)) begin
                        phase_in = PH_DEAD; emit = 1'b1; r.kind = wsrd_pkg::KIND_ERROR;
                     end else begin
                        if (tk == 4'd0) msg_in = sum_m[W-1:0];
                        else if ((tk == 4'd1 || tk == 4'd2) && !tfin) begin
                           frag_in = tk[1:0]; msg_in = flen_in;
                        end
                        tfrag = frag_in;
                        pay_in = '0;
                        if (flen_in != '0) begin
                           phase_in = PH_PAYLOAD;
                        end else begin
                           if (tk == 4'd9) begin
                              emit = 1'b1; r.kind = wsrd_pkg::KIND_PONG; r.last = 1'b1;
                           end else if (tfin && (tk == 4'd1 ||
                                        (tk == 4'd0 && tfrag == 2'd1))) begin
                              emit = 1'b1; r.kind = wsrd_pkg::KIND_TEXT; r.last = 1'b1;
                           end
                           if (tk == 4'd0 && tfin) begin
                              frag_in = '0; msg_in = '0;
                           end
                           phase_in = PH_HEADER; hidx_in = '0;
                        end
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               case (pay_ff[1:0])
                  2'd0: kb = key_ff[31:24];
                  2'd1: kb = key_ff[23:16];
                  2'd2: kb = key_ff[15:8];
                  default: kb = key_ff[7:0];
               endcase
               if (!masked_ff) kb = '0;
               is_last = ({1'b0, pay_ff} + 1'b1) >= {1'b0, flen_ff};
               pay_in = pay_ff + 1'b1;
               r.payload_byte = in_byte ^ kb;
               r.byte_valid = 1'b1;
               if (fkind_ff == 4'd9) begin
                  emit = 1'b1; r.kind = wsrd_pkg::KIND_PONG; r.last = is_last;
               end else if (text_cls) begin
                  emit = 1'b1; r.kind = wsrd_pkg::KIND_TEXT; r.last = is_last & fin_ff;
               end
               if (!emit) r = '0;
               if (is_last) begin
                  if (fkind_ff == 4'd0 && fin_ff) begin
                     frag_in = '0; msg_in = '0;
                  end
                  phase_in = PH_HEADER; hidx_in = '0; pay_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SHAKE; pidx_ff <= '0; pbad_ff <= 1'b0; blank_ff <= '0;
         reply_ff <= '0; hidx_ff <= '0; fin_ff <= 1'b0; fkind_ff <= '0;
         masked_ff <= 1'b0; flen_ff <= '0; ovf_ff <= 1'b0; pay_ff <= '0;
         key_ff <= '0; frag_ff <= '0; msg_ff <= '0; ext_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in; pidx_ff <= pidx_in; pbad_ff <= pbad_in;
         blank_ff <= blank_in; reply_ff <= reply_in; hidx_ff <= hidx_in;
         fin_ff <= fin_in; fkind_ff <= fkind_in; masked_ff <= masked_in;
         flen_ff <= flen_in; ovf_ff <= ovf_in; pay_ff <= pay_in; key_ff <= key_in;
         frag_ff <= frag_in; msg_ff <= msg_in; ext_ff <= ext_in;
      end
   end

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD && !in_action) |-> !q_valid)
      else $error("output in dead phase");
   a_pay_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (pay_ff < flen_ff))
      else $error("payload index past length");
   a_err_dead: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_data.kind == wsrd_pkg::KIND_ERROR) |=> (phase_ff == PH_DEAD))
      else $error("error without dead phase");
endmodule

@@ src/wsrd_queue.sv @@
`timescale 1ns / 1ps
module wsrd_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  wsrd_pkg::rsp_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output wsrd_pkg::rsp_type out_data
);
   wsrd_pkg::rsp_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
endmodule

@@ src/websocket_receive_deframer_core.sv @@
`timescale 1ns / 1ps
// Takes one received byte per cycle while req_tready is high and returns at most one
// result per byte. A front parser updates the handshake and frame state in the same
// cycle it accepts a byte and pushes any result into a two-entry queue; req_tready is
// the queue's not-full flag, so one byte a cycle is sustained while results drain.
module websocket_receive_deframer_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic req_tuser,         // action
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // payload_byte
   output logic [2:0] rsp_tuser,   // byte_valid, kind[1:0]
   output logic rsp_tlast          // last
);
   logic qv, qr;
   wsrd_pkg::rsp_type qd, od;

   wsrd_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tuser), .in_byte(req_tdata), .q_valid(qv), .q_ready(qr),
      .q_data(qd));

   wsrd_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(qv), .in_ready(qr), .in_data(qd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(od));

   assign rsp_tdata = od.payload_byte;
   assign rsp_tuser = {od.byte_valid, od.kind};
   assign rsp_tlast = od.last;
endmodule

@@ test/websocket_receive_deframer_core_checker.sv @@
`timescale 1ns / 1ps
module websocket_receive_deframer_core_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [7:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [2:0] rsp_tuser,
   input  logic rsp_tlast,
   output int fail_count,
   output int pending_count
);
   typedef enum logic [3:0] {
      PH_SHAKE = 4'b0001,
      PH_HDR = 4'b0010,
      PH_BODY = 4'b0100,
      PH_DEAD = 4'b1000
   } phase_type;

   localparam logic [7:0] StatusText [12] = '{"H", "T", "T", "P", "/", "1", ".", "1", " ",
      "1", "0", "1"};
   localparam logic [7:0] BlankText [4] = '{8'd13, 8'd10, 8'd13, 8'd10};
   localparam logic [1:0] FragNone = 2'd0;
   localparam logic [1:0] FragText = 2'd1;

   wsrd_pkg::rsp_type expected_rsps [$];

   phase_type phase;
   int unsigned prefix_index, blank_match, reply_count, header_index, ext_count;
   int unsigned frame_length, payload_index, message_count;
   logic frame_final, frame_masked, overflow;
   logic [3:0] frame_op;
   logic [31:0] mask_key;
   logic prefix_bad;
   logic [1:0] frag;

   task automatic clear_state();
      phase = PH_SHAKE;
      prefix_index = 0; prefix_bad = 0; blank_match = 0; reply_count = 0;
      header_index = 0; ext_count = 0; frame_length = 0; payload_index = 0;
      message_count = 0; frame_final = 0; frame_masked = 0; overflow = 0;
      frame_op = '0; mask_key = '0; frag = FragNone;
   endtask

   function automatic wsrd_pkg::rsp_type make_rsp(wsrd_pkg::kind_type k, logic [7:0] b,
                                                  logic v, logic l);
      wsrd_pkg::rsp_type r;
      r.kind = k; r.payload_byte = b; r.byte_valid = v; r.last = l;
      return r;
   endfunction

   function automatic logic is_text();
      return frame_op == wsrd_pkg::OpText ||
         (frame_op == wsrd_pkg::OpCont && frag == FragText);
   endfunction

   task automatic raise_error();
      phase = PH_DEAD;
      expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0));
   endtask

   task automatic close_frame();
      if (frame_op == wsrd_pkg::OpCont && frame_final) begin
         frag = FragNone;
         message_count = 0;
      end
      phase = PH_HDR;
      header_index = 0;
      payload_index = 0;
   endtask

   task automatic finish_header(int unsigned hdr_len);
      if (overflow || frame_length > wsrd_pkg::MaxBytes ||
          hdr_len + frame_length > wsrd_pkg::MaxBytes) begin
         raise_error();
         return;
      end
      if (frame_op[3] && (!frame_final || frame_length > 125)) begin
         raise_error();
         return;
      end
      if (frame_op == wsrd_pkg::OpCont) begin
         if (frag == FragNone || message_count + frame_length > wsrd_pkg::MaxBytes) begin
            raise_error();
            return;
         end
         message_count += frame_length;
      end else if (frame_op == wsrd_pkg::OpText || frame_op == wsrd_pkg::OpBinary) begin
         if (frag != FragNone) begin
            raise_error();
            return;
         end
         if (!frame_final) begin
            frag = frame_op[1:0];
            message_count = frame_length;
         end
      end else if (frame_op != wsrd_pkg::OpPing && frame_op != wsrd_pkg::OpPong) begin
         raise_error();
         return;
      end
      payload_index = 0;
      if (frame_length != 0) begin
         phase = PH_BODY;
         return;
      end
      if (frame_op == wsrd_pkg::OpPing)
         expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_PONG, 8'd0, 1'b0, 1'b1));
      else if (frame_final && is_text())
         expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b1));
      close_frame();
   endtask

   task automatic predict_byte(logic new_conn, logic [7:0] b);
      int unsigned hdr_len;
      logic [7:0] v;
      logic at_end;
      if (new_conn) begin
         clear_state();
         return;
      end
      case (phase)
         PH_SHAKE: begin
            reply_count++;
            if (reply_count > wsrd_pkg::MaxBytes) begin
               raise_error();
               return;
            end
            if (prefix_index < 12 && !prefix_bad) begin
               if (b == StatusText[prefix_index] || (prefix_index == 7 && b == "0"))
                  prefix_index++;
               else
                  prefix_bad = 1;
            end
            if (b == BlankText[blank_match]) begin
               if (blank_match == 3) begin
                  if (prefix_bad || prefix_index < 12) begin
                     raise_error();
                     return;
                  end
                  phase = PH_HDR;
                  header_index = 0;
                  expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_ACCEPT, 8'd0, 1'b0, 1'b0));
                  return;
               end
               blank_match++;
            end else begin
               blank_match = (b == 8'd13) ? 1 : 0;
            end
         end
         PH_HDR: begin
            if (header_index == 0) begin
               frame_final = b[7];
               frame_op = b[3:0];
               header_index = 1;
               return;
            end
            if (header_index == 1) begin
               frame_masked = b[7];
               ext_count = (b[6:0] == 126) ? 2 : (b[6:0] == 127) ? 8 : 0;
               frame_length = ext_count != 0 ? 0 : b[6:0];
               overflow = 0;
               mask_key = '0;
            end else if (header_index - 2 < ext_count) begin
               frame_length = (frame_length << 8) | b;
               if (frame_length > wsrd_pkg::MaxBytes) begin
                  overflow = 1;
                  frame_length = wsrd_pkg::MaxBytes + 1;
               end
            end else begin
               mask_key = {mask_key[23:0], b};
            end
            header_index++;
            hdr_len = 2 + ext_count + (frame_masked ? 4 : 0);
            if (header_index >= hdr_len)
               finish_header(hdr_len);
         end
         PH_BODY: begin
            v = b;
            if (frame_masked)
               v ^= mask_key[8 * (3 - payload_index % 4) +: 8];
            at_end = payload_index + 1 >= frame_length;
            payload_index++;
            if (frame_op == wsrd_pkg::OpPing)
               expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_PONG, v, 1'b1, at_end));
            else if (is_text())
               expected_rsps.push_back(make_rsp(wsrd_pkg::KIND_TEXT, v, 1'b1,
                                                at_end & frame_final));
            if (at_end)
               close_frame();
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      clear_state();
   end

   always @(posedge clock) begin
      wsrd_pkg::rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_byte(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction kind", rsp_tuser[1:0], 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser[1:0] != want.kind)
                  report_mismatch("kind", rsp_tuser[1:0], want.kind);
               if (rsp_tdata != want.payload_byte)
                  report_mismatch("payload_byte", rsp_tdata, want.payload_byte);
               if (rsp_tuser[2] != want.byte_valid)
                  report_mismatch("byte_valid", rsp_tuser[2], want.byte_valid);
               if (rsp_tlast != want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
         pending_count = expected_rsps.size();
      end
   end
endmodule

@@ test/websocket_receive_deframer_core_tb.sv @@
`timescale 1ns / 1ps
module websocket_receive_deframer_core_tb;
   localparam int CycleLimit = 1500000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   int fail_count, pending_count;
   int send_idle_pct = 25;
   int recv_idle_pct = 50;
   int hold_cycles = 0;
   int sent_count = 0;
   int loop_base = 0;
   longint cycle_count = 0;

   always #2 clock = ~clock;

   websocket_receive_deframer_core u_dut (.*);

   websocket_receive_deframer_core_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("[websocket_receive_deframer_core] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 0;
      else if (hold_cycles > 0) begin
         rsp_tready <= 0;
         hold_cycles--;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic act, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(0, s[i]);
   endtask

   task automatic open_conn();
      send_item(1, 8'h00);
      if ($urandom_range(1)) send_text("HTTP/1.1 101 OK\r\nUpgrade: x\r\n\r\n");
      else send_text("HTTP/1.0 101\r\n\r\n");
   endtask

   task automatic put_frame(logic fin, logic [3:0] op, int unsigned len, logic masked,
                            int size_mode);
      logic [31:0] key;
      key = $urandom;
      send_item(0, {fin, 3'($urandom), op});
      if (size_mode == 0) begin
         send_item(0, {masked, 7'(len)});
      end else if (size_mode == 1) begin
         send_item(0, {masked, 7'd126});
         send_item(0, len[15:8]);
         send_item(0, len[7:0]);
      end else begin
         send_item(0, {masked, 7'd127});
         for (int i = 7; i >= 0; i--) send_item(0, i >= 4 ? 8'h00 : len[8 * i +: 8]);
      end
      if (masked)
         for (int i = 3; i >= 0; i--) send_item(0, key[8 * i +: 8]);
      for (int unsigned i = 0; i < len && i < 300; i++) send_item(0, 8'($urandom));
   endtask

   task automatic random_frame();
      int pick;
      int unsigned len;
      logic [3:0] op;
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
      op = (pick < 40) ? wsrd_pkg::OpText : (pick < 60) ? wsrd_pkg::OpCont
         : (pick < 70) ? wsrd_pkg::OpPing : (pick < 78) ? wsrd_pkg::OpPong
         : (pick < 85) ? wsrd_pkg::OpBinary : 4'($urandom);
      put_frame($urandom_range(3) != 0, op, len, $urandom_range(1),
                len > 125 ? 1 : ($urandom_range(9) == 0 ? 2 : 0));
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_text("HTTP/1.1 101 Switching\r\n\r\n");
      put_frame(1, wsrd_pkg::OpText, 3, 1, 0);
      put_frame(0, wsrd_pkg::OpText, 0, 0, 0);
      put_frame(1, wsrd_pkg::OpCont, 0, 0, 0);
      put_frame(1, wsrd_pkg::OpPing, 0, 1, 0);
      put_frame(1, wsrd_pkg::OpPing, 2, 0, 1);
      put_frame(1, wsrd_pkg::OpPong, 1, 0, 0);
      put_frame(1, wsrd_pkg::OpBinary, 2, 0, 2);
      put_frame(1, wsrd_pkg::OpClose, 0, 0, 0);
      send_item(0, 8'hff);
      send_item(0, 8'h00);
      send_item(1, 8'hff);
      send_text("HTTP/1.0 102\r\n\r\n");
      send_item(1, 8'h00);
      send_text("HT\r\n\r\n");
      open_conn();
      put_frame(0, wsrd_pkg::OpPing, 0, 0, 0);
      open_conn();
      put_frame(1, wsrd_pkg::OpText, 9000, 0, 2);
      open_conn();
      put_frame(1, wsrd_pkg::OpCont, 1, 0, 0);

      hold_cycles = 300;
      open_conn();
      repeat (30) put_frame(1, wsrd_pkg::OpText, 4, 0, 0);
      wait_drained();

      loop_base = sent_count;
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 25 : (p == 1) ? 50 : 0;
         recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 25 : 0;
         while (sent_count < loop_base + 200 * (p + 1)) begin
            if ($urandom_range(29) == 0) begin
               send_item(1, 8'h00);
               repeat ($urandom_range(20)) send_item(0, 8'($urandom));
            end
            if ($urandom_range(14) == 0) open_conn();
            random_frame();
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("[websocket_receive_deframer_core] OK");
      else
         $display("[websocket_receive_deframer_core] ERROR");
      $finish;
   end
endmodule

@@ filelist.f @@
src/wsrd_pkg.sv
src/wsrd_front.sv
src/wsrd_queue.sv
src/websocket_receive_deframer_core.sv
test/websocket_receive_deframer_core_checker.sv
test/websocket_receive_deframer_core_tb.sv
